FILE: rtl/acgpm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the audio channel gain and peak meter.
// No dependencies; imported by the top level and its port checker.
package acgpm_pkg;

  localparam int unsigned MaxChannels = 6;
  localparam int unsigned SampleW     = 16;
  localparam int unsigned GainW       = 16;
  localparam int unsigned GainFracW   = 12;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [GainW-1:0] GainUnity       = GainW'(1 << GainFracW);
  localparam logic [ChanW-1:0] DefaultChannels = ChanW'(2);
  localparam logic [ChanW-1:0] MaxChanCode     = ChanW'(MaxChannels);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHANNEL_COUNT = 3'd0,
    CFG_MUTE_MASK     = 3'd1,
    CFG_GAIN_CH0      = 3'd2,
    CFG_GAIN_CH1      = 3'd3,
    CFG_GAIN_CH2      = 3'd4,
    CFG_GAIN_CH3      = 3'd5,
    CFG_GAIN_CH4      = 3'd6,
    CFG_GAIN_CH5      = 3'd7
  } cfg_reg_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

endpackage

FILE: rtl/audio_channel_gain_peak_meter.sv
`timescale 1ns / 1ps
// Top level of the audio channel gain and peak meter.
// Depends on acgpm_pkg for widths, register indexes and result kinds.

// Interleaved signed 16-bit PCM samples enter through an input register, get their
// channel's Q4.12 gain (truncated toward zero, saturated to 16 bits), update that
// channel's absolute peak and leave through a result register, one item per cycle.
// A sample marked as buffer end produces its sample result followed by one peak
// report per active channel, where a count of zero acts as one and a count above six
// as six, so it holds the result register for the sample result and every report;
// the next item waits in the input register meanwhile. An accepted item passes from
// the input register to the result register, and a stalled output holds the input
// back once both registers are full. Configuration writes are always accepted and
// should only be issued while the block is idle.
module audio_channel_gain_peak_meter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [acgpm_pkg::SampleW-1:0] sample_in_i,
  input  logic                               buffer_end_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               kind_o,
  output logic signed [acgpm_pkg::SampleW-1:0] sample_out_o,
  output logic        [acgpm_pkg::ChanW-1:0]   channel_o,
  output logic        [acgpm_pkg::SampleW-1:0] peak_o,
  output logic                               last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic        [acgpm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic        [acgpm_pkg::CfgDataW-1:0] cfg_data_i
);
  import acgpm_pkg::*;

  logic [ChanW-1:0]       chan_count_q;
  logic [MaxChannels-1:0] mute_q;
  logic [GainW-1:0]       gain_q [MaxChannels];

  logic                      in_v_q;
  logic signed [SampleW-1:0] in_sample_q;
  logic                      in_end_q;

  logic [ChanW-1:0]   chan_idx_q, chan_idx_d;
  logic [SampleW-1:0] peak_q [MaxChannels];
  logic [SampleW-1:0] snap_q [MaxChannels];

  logic                      out_v_q, out_v_d;
  kind_e                     out_kind_q, out_kind_d;
  logic signed [SampleW-1:0] out_sample_q, out_sample_d;
  logic [ChanW-1:0]          out_chan_q, out_chan_d;
  logic [SampleW-1:0]        out_peak_q, out_peak_d;
  logic                      out_last_q, out_last_d;
  logic                      pend_q, pend_d;
  logic [ChanW-1:0]          rpt_idx_q, rpt_idx_d;
  logic [ChanW-1:0]          rpt_n_q, rpt_n_d;

  logic                      pop, proc_fire, rpt_last;
  logic [ChanW-1:0]          n_act, ch, ch_inc;
  logic signed [32:0]        prod, prod_b;
  logic signed [20:0]        quo;
  logic signed [SampleW-1:0] gained;
  logic [SampleW-1:0]        mag, new_pk;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= DefaultChannels;
      mute_q       <= '0;
      for (int i = 0; i < MaxChannels; i++) begin
        gain_q[i] <= GainUnity;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CHANNEL_COUNT: chan_count_q <= cfg_data_i[ChanW-1:0];
        CFG_MUTE_MASK:     mute_q <= cfg_data_i[MaxChannels-1:0];
        CFG_GAIN_CH0:      gain_q[0] <= cfg_data_i[GainW-1:0];
        CFG_GAIN_CH1:      gain_q[1] <= cfg_data_i[GainW-1:0];
        CFG_GAIN_CH2:      gain_q[2] <= cfg_data_i[GainW-1:0];
        CFG_GAIN_CH3:      gain_q[3] <= cfg_data_i[GainW-1:0];
        CFG_GAIN_CH4:      gain_q[4] <= cfg_data_i[GainW-1:0];
        CFG_GAIN_CH5:      gain_q[5] <= cfg_data_i[GainW-1:0];
        default:           chan_count_q <= chan_count_q;
      endcase
    end
  end

  assign pop        = out_v_q && out_ready_i;
  assign proc_fire  = in_v_q && (!out_v_q || (out_ready_i && !pend_q));
  assign in_ready_o = !in_v_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_ready_o) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_sample_q <= sample_in_i;
      in_end_q    <= buffer_end_i;
    end
  end

  always_comb begin
    if (chan_count_q == '0) begin
      n_act = ChanW'(1);
    end else if (chan_count_q > MaxChanCode) begin
      n_act = MaxChanCode;
    end else begin
      n_act = chan_count_q;
    end
    ch     = (chan_idx_q >= n_act) ? '0 : chan_idx_q;
    ch_inc = ChanW'(ch + ChanW'(1));

    prod   = in_sample_q * $signed({1'b0, gain_q[ch]});
    prod_b = prod + (prod[32] ? 33'sd4095 : 33'sd0);
    quo    = prod_b[32:GainFracW];
    if (quo > 21'sd32767) begin
      gained = 16'sh7fff;
    end else if (quo < -21'sd32768) begin
      gained = 16'sh8000;
    end else begin
      gained = quo[SampleW-1:0];
    end
    mag    = gained[SampleW-1] ? SampleW'(~gained + 16'sd1) : gained;
    new_pk = (mag > peak_q[ch]) ? mag : peak_q[ch];

    if (in_end_q || ch_inc >= n_act) begin
      chan_idx_d = '0;
    end else begin
      chan_idx_d = ch_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_idx_q <= '0;
      for (int i = 0; i < MaxChannels; i++) begin
        peak_q[i] <= '0;
      end
    end else if (proc_fire) begin
      chan_idx_q <= chan_idx_d;
      for (int i = 0; i < MaxChannels; i++) begin
        if (in_end_q) begin
          peak_q[i] <= '0;
        end else if (ChanW'(i) == ch) begin
          peak_q[i] <= new_pk;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && in_end_q) begin
      for (int i = 0; i < MaxChannels; i++) begin
        snap_q[i] <= (ChanW'(i) == ch) ? new_pk : peak_q[i];
      end
    end
  end

  assign rpt_last = (ChanW'(rpt_idx_q + ChanW'(1)) == rpt_n_q);

  always_comb begin
    out_v_d      = out_v_q;
    out_kind_d   = out_kind_q;
    out_sample_d = out_sample_q;
    out_chan_d   = out_chan_q;
    out_peak_d   = out_peak_q;
    out_last_d   = out_last_q;
    pend_d       = pend_q;
    rpt_idx_d    = rpt_idx_q;
    rpt_n_d      = rpt_n_q;
    priority if (proc_fire) begin
      out_v_d      = 1'b1;
      out_kind_d   = KIND_SAMPLE;
      out_sample_d = mute_q[ch] ? '0 : gained;
      out_chan_d   = ch;
      out_peak_d   = new_pk;
      out_last_d   = !in_end_q;
      pend_d       = in_end_q;
      rpt_idx_d    = '0;
      rpt_n_d      = n_act;
    end else if (pop && pend_q) begin
      out_kind_d   = KIND_REPORT;
      out_sample_d = '0;
      out_chan_d   = rpt_idx_q;
      out_peak_d   = snap_q[rpt_idx_q];
      out_last_d   = rpt_last;
      pend_d       = !rpt_last;
      rpt_idx_d    = ChanW'(rpt_idx_q + ChanW'(1));
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      pend_q    <= 1'b0;
      rpt_idx_q <= '0;
      rpt_n_q   <= '0;
    end else begin
      out_v_q   <= out_v_d;
      pend_q    <= pend_d;
      rpt_idx_q <= rpt_idx_d;
      rpt_n_q   <= rpt_n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q   <= out_kind_d;
    out_sample_q <= out_sample_d;
    out_chan_q   <= out_chan_d;
    out_peak_q   <= out_peak_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_v_q;
  assign kind_o       = out_kind_q;
  assign sample_out_o = out_sample_q;
  assign channel_o    = out_chan_q;
  assign peak_o       = out_peak_q;
  assign last_o       = out_last_q;

endmodule

FILE: rtl/acgpm_port_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the audio channel gain and peak meter, bound to the top level.
// Depends on acgpm_pkg for widths and the result kinds.
module acgpm_port_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic                               kind_o,
  input logic signed [acgpm_pkg::SampleW-1:0] sample_out_o,
  input logic        [acgpm_pkg::ChanW-1:0]   channel_o,
  input logic        [acgpm_pkg::SampleW-1:0] peak_o,
  input logic                               last_o
);
  import acgpm_pkg::*;

  logic out_acc;
  assign out_acc = out_valid_o && out_ready_i;

  // A stalled result stays valid and keeps its peak and last flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(peak_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Peak reports carry no sample and a peak of at most full scale.
  a_report_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REPORT |->
      sample_out_o == '0 && (!peak_o[SampleW-1] || peak_o[SampleW-2:0] == '0))
    else $error("malformed peak report");

  // A result that is not the last of its item is directly followed by a report.
  a_report_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o |=> out_valid_o && kind_o == KIND_REPORT)
    else $error("missing peak report");

  // Reports walk the channels in order.
  a_report_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o && kind_o == KIND_REPORT |=>
      channel_o == ChanW'($past(channel_o) + ChanW'(1)))
    else $error("peak reports out of order");

endmodule

bind audio_channel_gain_peak_meter acgpm_port_checker u_acgpm_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .kind_o       (kind_o),
  .sample_out_o (sample_out_o),
  .channel_o    (channel_o),
  .peak_o       (peak_o),
  .last_o       (last_o)
);
